FILE: src/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/lpg_pkg.sv
// ----------------------------------------------------------------------------
// lpg_pkg
// Types and constants for the line point generator.
// ----------------------------------------------------------------------------
package lpg_pkg;

  localparam int COORD_BITS = 12;
  localparam int FIELD_BITS = 12;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_NEXT  = 1'b1;

  typedef struct packed {
    logic                  action;
    logic [FIELD_BITS-1:0] x_first;
    logic [FIELD_BITS-1:0] y_first;
    logic [FIELD_BITS-1:0] x_second;
    logic [FIELD_BITS-1:0] y_second;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] point_x;
    logic [FIELD_BITS-1:0] point_y;
    logic                  last_point;
    logic                  point_valid;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

FILE: src/line_point_generator_top.sv
// ----------------------------------------------------------------------------
// line_point_generator_top
// Walks a straight segment one pixel per transaction along the major axis,
// minor coordinate from an exact truncated division.
// ----------------------------------------------------------------------------
//  channel | direction | payload            | handshake
//  in_     | input     | lpg_pkg::in_item_t  | in_valid / in_ready
//  out_    | output    | lpg_pkg::out_item_t | out_valid / out_ready
//
//  Start, or next request while idle: result registered in S_DONE, then in the
//  output register; in_ready returns on the load. Next point: S_MUL, S_DIVGO,
//  then S_DIV on the restoring divider, one quotient bit per cycle, then S_DONE.
//  Synchronous active-low reset clears the sequencer and the segment.
//  in_ready stays low while a point is in work; a stalled output only blocks
//  once the following result is ready to be loaded.
// ----------------------------------------------------------------------------
module line_point_generator_top #(
  parameter int COORD_BITS = lpg_pkg::COORD_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lpg_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lpg_pkg::out_item_t out_data
);

  localparam int CB = COORD_BITS;
  localparam int FB = lpg_pkg::FIELD_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIVGO,
    S_DIV,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic [CB-1:0]   major_pos_r, major_pos_nxt;
  logic [CB-1:0]   major1_r, major1_nxt;
  logic [CB-1:0]   minor0_r, minor0_nxt;
  logic [CB-1:0]   dminor_r, dminor_nxt;
  logic [CB-1:0]   span_r, span_nxt;
  logic [CB-1:0]   t_r, t_nxt;
  logic            minor_neg_r, minor_neg_nxt;
  logic            major_is_x_r, major_is_x_nxt;
  logic            seg_active_r, seg_active_nxt;
  logic            last_r, last_nxt;
  logic [2*CB-1:0] prod_r, prod_nxt;
  lpg_pkg::out_item_t res_r, res_nxt;
  lpg_pkg::out_item_t out_data_r, out_data_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic [CB-1:0] x0, y0, x1, y1, dx, dy;
  logic [CB-1:0] s_minor1;
  logic          mx;
  logic          accept;

  logic                 div_start;
  lpg_pkg::div_status_t div_status;
  logic [CB-1:0]        div_quot;
  logic                 div_rem_nz;
  logic [CB-1:0]        q_adj;
  logic [CB-1:0]        minor;

  function automatic logic [CB-1:0] abs_diff(input logic [CB-1:0] a, input logic [CB-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  assign x0 = CB'(in_data.x_first);
  assign y0 = CB'(in_data.y_first);
  assign x1 = CB'(in_data.x_second);
  assign y1 = CB'(in_data.y_second);
  assign dx = abs_diff(x0, x1);
  assign dy = abs_diff(y0, y1);
  assign mx = (dx >= dy);
  assign s_minor1 = mx ? y1 : x1;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign div_start = (state_r == S_DIVGO);

  // Descending minor axis needs a ceiling: floor plus one on a remainder.
  assign q_adj = div_quot + CB'(minor_neg_r && div_rem_nz);
  assign minor = minor_neg_r ? (minor0_r - q_adj) : (minor0_r + q_adj);

  lpg_div #(.CB(CB)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (prod_r),
    .den    (span_r),
    .status (div_status),
    .quot   (div_quot),
    .rem_nz (div_rem_nz)
  );

  always_comb begin
    state_nxt      = state_r;
    major_pos_nxt  = major_pos_r;
    major1_nxt     = major1_r;
    minor0_nxt     = minor0_r;
    dminor_nxt     = dminor_r;
    span_nxt       = span_r;
    t_nxt          = t_r;
    minor_neg_nxt  = minor_neg_r;
    major_is_x_nxt = major_is_x_r;
    seg_active_nxt = seg_active_r;
    last_nxt       = last_r;
    prod_nxt       = prod_r;
    res_nxt        = res_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.action == lpg_pkg::ACT_START) begin
            major_is_x_nxt = mx;
            major_pos_nxt  = mx ? x0 : y0;
            major1_nxt     = mx ? x1 : y1;
            minor0_nxt     = mx ? y0 : x0;
            span_nxt       = mx ? dx : dy;
            dminor_nxt     = mx ? dy : dx;
            minor_neg_nxt  = s_minor1 < (mx ? y0 : x0);
            t_nxt          = '0;
            seg_active_nxt = !((x0 == x1) && (y0 == y1));
            res_nxt.point_x     = FB'(x0);
            res_nxt.point_y     = FB'(y0);
            res_nxt.last_point  = (x0 == x1) && (y0 == y1);
            res_nxt.point_valid = 1'b1;
            state_nxt = S_DONE;
          end else if (seg_active_r) begin
            if (major_pos_r < major1_r) begin
              major_pos_nxt = major_pos_r + 1'b1;
            end else if (major_pos_r > major1_r) begin
              major_pos_nxt = major_pos_r - 1'b1;
            end
            t_nxt    = t_r + 1'b1;
            last_nxt = (major_pos_nxt == major1_r);
            if (last_nxt) seg_active_nxt = 1'b0;
            state_nxt = S_MUL;
          end else begin
            res_nxt   = '0;
            state_nxt = S_DONE;
          end
        end
      end
      S_MUL: begin
        prod_nxt  = {{CB{1'b0}}, dminor_r} * {{CB{1'b0}}, t_r};
        state_nxt = S_DIVGO;
      end
      S_DIVGO: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_status.done) begin
          res_nxt.point_x     = FB'(major_is_x_r ? major_pos_r : minor);
          res_nxt.point_y     = FB'(major_is_x_r ? minor : major_pos_r);
          res_nxt.last_point  = last_r;
          res_nxt.point_valid = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      seg_active_r <= 1'b0;
      major_is_x_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      seg_active_r <= seg_active_nxt;
      major_is_x_r <= major_is_x_nxt;
    end
    major_pos_r <= major_pos_nxt;
    major1_r    <= major1_nxt;
    minor0_r    <= minor0_nxt;
    dminor_r    <= dminor_nxt;
    span_r      <= span_nxt;
    t_r         <= t_nxt;
    minor_neg_r <= minor_neg_nxt;
    last_r      <= last_nxt;
    prod_r      <= prod_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: src/lpg_div.sv
// ----------------------------------------------------------------------------
// lpg_div
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits in CB bits (upper half of the numerator below the divisor).
// ----------------------------------------------------------------------------
module lpg_div #(
  parameter int CB = lpg_pkg::COORD_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [2*CB-1:0]     num,
  input  logic [CB-1:0]       den,
  output lpg_pkg::div_status_t status,
  output logic [CB-1:0]       quot,
  output logic                rem_nz
);

  localparam int CW = (CB > 1) ? $clog2(CB) : 1;
  localparam logic [CW-1:0] LAST_STEP = CW'(CB - 1);

  logic [CB-1:0] rem_r, rem_nxt;
  logic [CB-1:0] lo_r, lo_nxt;
  logic [CB-1:0] den_r, den_nxt;
  logic [CB-1:0] quot_r, quot_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  logic [CB:0]   shifted;
  logic [CB:0]   diff;
  logic          ge;

  assign shifted = {rem_r, lo_r[CB-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = shifted >= {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num[2*CB-1:CB];
      lo_nxt   = num[CB-1:0];
      den_nxt  = den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[CB-1:0] : shifted[CB-1:0];
      lo_nxt   = {lo_r[CB-2:0], 1'b0};
      quot_nxt = {quot_r[CB-2:0], ge};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    lo_r   <= lo_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quot        = quot_r;
  assign rem_nz      = (rem_r != '0);

endmodule

FILE: src/lpg_checker.sv
// ----------------------------------------------------------------------------
// lpg_checker
// Port-level checks on the line point generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpg_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input lpg_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input lpg_pkg::out_item_t out_data
);

  logic in_xact;
  logic out_stall;

  assign in_xact   = in_valid && in_ready && (in_data.action == lpg_pkg::ACT_START
                     || in_data.action == lpg_pkg::ACT_NEXT);
  assign out_stall = out_valid && !out_ready;

  `ASSERT_CLK(a_out_hold, out_stall |=> out_valid, "out_valid dropped while stalled")
  `ASSERT_CLK(a_out_stable, out_stall |=> $stable(out_data), "out_data changed while stalled")
  `ASSERT_CLK(a_busy_after_xact, in_xact |=> !in_ready, "in_ready held after a transaction")
  `ASSERT_ALWAYS(a_last_valid, (out_valid && out_data.last_point) |-> out_data.point_valid, "last point without valid point")

endmodule

bind line_point_generator_top lpg_checker u_lpg_checker (.*);

FILE: sim/line_point_generator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_point_generator_top_tb
// Drives start and next-point transactions into the line point generator,
// including idle requests, single-point segments, every axis/direction,
// restarts, long random walks, output stalls and drain pauses. A predictor
// tracks the segment walk and every result is checked field by field.
// ----------------------------------------------------------------------------
module line_point_generator_top_tb;

  localparam int CB          = lpg_pkg::COORD_BITS;
  localparam int FB          = lpg_pkg::FIELD_BITS;
  localparam int CMAX        = (1 << CB) - 1;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = CB + 8;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  lpg_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  lpg_pkg::out_item_t out_data;

  line_point_generator_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  // Predicted segment walk
  logic [CB-1:0] end_a_x, end_a_y, end_b_x, end_b_y;
  logic [CB-1:0] walk_pos;
  logic          x_major;
  logic          walking;

  lpg_pkg::out_item_t pending_points[$];
  lpg_pkg::out_item_t exp_point;

  int  items_sent;
  int  points_checked;
  int  segments_started;
  int  error_count;
  int  stall_cycles;
  int  hold_cycles;
  bit  no_idle;

  function automatic logic [CB-1:0] axis_dist(logic [CB-1:0] a, logic [CB-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Exact line value along the minor axis, rounded toward minus infinity.
  function automatic logic [CB-1:0] minor_coord(logic [CB-1:0] m0,
                                                logic [CB-1:0] m1,
                                                logic [CB-1:0] t,
                                                logic [CB-1:0] span);
    longint unsigned delta;
    longint unsigned steps;
    longint unsigned div;
    longint unsigned q;
    if (span == '0) return m0;
    steps = t;
    div   = span;
    if (m1 >= m0) begin
      delta = m1 - m0;
      q     = (delta * steps) / div;
      return m0 + q[CB-1:0];
    end
    delta = m0 - m1;
    q     = (delta * steps + div - 1) / div;
    return m0 - q[CB-1:0];
  endfunction

  function automatic lpg_pkg::out_item_t trace_point(lpg_pkg::in_item_t item);
    lpg_pkg::out_item_t res;
    logic [CB-1:0]      a0, a1, m0, m1, span, t, mn;
    res = '0;
    if (item.action == lpg_pkg::ACT_START) begin
      end_a_x = item.x_first;
      end_a_y = item.y_first;
      end_b_x = item.x_second;
      end_b_y = item.y_second;
      x_major  = axis_dist(end_a_x, end_b_x) >= axis_dist(end_a_y, end_b_y);
      walk_pos = x_major ? end_a_x : end_a_y;
      res.point_x     = end_a_x;
      res.point_y     = end_a_y;
      res.last_point  = (end_a_x == end_b_x) && (end_a_y == end_b_y);
      res.point_valid = 1'b1;
      walking = !res.last_point;
    end else if (walking) begin
      a0 = x_major ? end_a_x : end_a_y;
      a1 = x_major ? end_b_x : end_b_y;
      m0 = x_major ? end_a_y : end_a_x;
      m1 = x_major ? end_b_y : end_b_x;
      span = axis_dist(a0, a1);
      if (walk_pos < a1) walk_pos = walk_pos + 1'b1;
      else if (walk_pos > a1) walk_pos = walk_pos - 1'b1;
      t = axis_dist(walk_pos, a0);
      if (t > span) t = span;
      mn = minor_coord(m0, m1, t, span);
      res.point_x     = x_major ? walk_pos : mn;
      res.point_y     = x_major ? mn : walk_pos;
      res.last_point  = (walk_pos == a1);
      res.point_valid = 1'b1;
      if (res.last_point) walking = 1'b0;
    end
    return res;
  endfunction

  function automatic lpg_pkg::in_item_t start_item(int x0, int y0, int x1, int y1);
    lpg_pkg::in_item_t item;
    item.action   = lpg_pkg::ACT_START;
    item.x_first  = FB'(x0);
    item.y_first  = FB'(y0);
    item.x_second = FB'(x1);
    item.y_second = FB'(y1);
    return item;
  endfunction

  // Coordinates of a next request are don't-care; keep them toggling.
  function automatic lpg_pkg::in_item_t next_item();
    lpg_pkg::in_item_t item;
    item.action   = lpg_pkg::ACT_NEXT;
    item.x_first  = FB'($urandom);
    item.y_first  = FB'($urandom);
    item.x_second = FB'($urandom);
    item.y_second = FB'($urandom);
    return item;
  endfunction

  function automatic int shift_coord(int c, int mag);
    if (c + mag > CMAX) return c - mag;
    if (c < mag) return c + mag;
    return $urandom_range(1) ? c + mag : c - mag;
  endfunction

  // Called and returns at a falling edge; valid stays high on return.
  task automatic send_item(lpg_pkg::in_item_t item);
    while (!no_idle && $urandom_range(99) < 12) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_points.push_back(trace_point(item));
    items_sent++;
    if (item.action == lpg_pkg::ACT_START) segments_started++;
    @(negedge clk);
  endtask

  task automatic walk(int n);
    repeat (n) send_item(next_item());
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_points.size() != 0) @(negedge clk);
  endtask

  task automatic test_idle_request();
    walk(1);
    send_item('{action: lpg_pkg::ACT_NEXT, x_first: '1, y_first: '1, x_second: '1,
                y_second: '1});
  endtask

  task automatic test_single_point();
    send_item(start_item(0, 0, 0, 0));
    send_item(start_item(CMAX, CMAX, CMAX, CMAX));
    walk(1);
  endtask

  task automatic test_axis_and_direction();
    // x major ascending with a truncated minor
    send_item(start_item(10, 5, 13, 7));
    walk(3);
    // y major descending, minor rounds down on a falling coordinate
    send_item(start_item(100, 50, 98, 46));
    walk(4);
    walk(1);
    // equal spans pick x as major, walking toward zero
    send_item(start_item(CMAX, CMAX, CMAX - 2, CMAX - 2));
    walk(2);
  endtask

  task automatic test_restart_mid_segment();
    send_item(start_item(CMAX, 0, CMAX - 5, CMAX));
    walk(3);
    send_item(start_item(0, CMAX, CMAX, 0));
    walk(2);
  endtask

  task automatic random_segment();
    int  x0, y0, x1, y1;
    int  major_mag, minor_mag, steps;
    bit  wide;
    wide = ($urandom_range(15) == 0);
    x0 = $urandom_range(CMAX);
    y0 = $urandom_range(CMAX);
    if (wide) begin
      x1 = $urandom_range(CMAX);
      y1 = $urandom_range(CMAX);
    end else begin
      major_mag = $urandom_range(12);
      minor_mag = $urandom_range(major_mag);
      if ($urandom_range(1)) begin
        x1 = shift_coord(x0, major_mag);
        y1 = shift_coord(y0, minor_mag);
      end else begin
        x1 = shift_coord(x0, minor_mag);
        y1 = shift_coord(y0, major_mag);
      end
    end
    send_item(start_item(x0, y0, x1, y1));
    steps = (x1 > x0 ? x1 - x0 : x0 - x1);
    if ((y1 > y0 ? y1 - y0 : y0 - y1) > steps) steps = (y1 > y0 ? y1 - y0 : y0 - y1);
    if (wide) steps = $urandom_range(6);
    else if ($urandom_range(7) == 0) steps = $urandom_range(steps);
    else if ($urandom_range(7) == 0) steps += $urandom_range(2, 1);
    walk(steps);
  endtask

  task automatic test_random_segments(int target);
    while (items_sent < target) random_segment();
  endtask

  // Output held off long enough that the block backs up into its input.
  task automatic test_output_backpressure();
    hold_cycles = HOLD_CYCLES;
    send_item(start_item(200, 300, 212, 291));
    walk(12);
    wait_drained();
  endtask

  task automatic test_drain_pause();
    send_item(start_item(4000, 17, 3993, 30));
    walk(5);
    wait_drained();
    walk(9);
  endtask

  // Result side: random ready, with a counted hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles != 0) begin
        out_ready = 1'b0;
        hold_cycles--;
      end else begin
        out_ready = rst_n && (no_idle || $urandom_range(99) >= 12);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t unexpected point x=%0d y=%0d last=%0b valid=%0b", $realtime,
                   out_data.point_x, out_data.point_y, out_data.last_point,
                   out_data.point_valid);
      end else begin
        exp_point = pending_points.pop_front();
        points_checked++;
        if (out_data.point_x !== exp_point.point_x ||
            out_data.point_y !== exp_point.point_y ||
            out_data.last_point !== exp_point.last_point ||
            out_data.point_valid !== exp_point.point_valid) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t point mismatch: exp x=%0d y=%0d last=%0b valid=%0b, got x=%0d y=%0d last=%0b valid=%0b",
                     $realtime, exp_point.point_x, exp_point.point_y, exp_point.last_point,
                     exp_point.point_valid, out_data.point_x, out_data.point_y,
                     out_data.last_point, out_data.point_valid);
        end
      end
    end
  end

  // Watchdog: cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles, %0d points outstanding", stall_cycles,
               pending_points.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    walking  = 1'b0;
    x_major  = 1'b0;
    walk_pos = '0;
    end_a_x  = '0;
    end_a_y  = '0;
    end_b_x  = '0;
    end_b_y  = '0;
    items_sent = 0;
    points_checked = 0;
    segments_started = 0;
    error_count = 0;
    stall_cycles = 0;
    hold_cycles = 0;
    no_idle = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_idle_request();
    test_single_point();
    test_axis_and_direction();
    test_restart_mid_segment();
    no_idle = 1'b1;
    test_random_segments(items_sent + 150);
    no_idle = 1'b0;
    test_output_backpressure();
    test_random_segments(items_sent + 400);
    test_drain_pause();
    test_random_segments(1000);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    error_count += pending_points.size();
    $display("covered %0d transactions in, %0d segments, %0d points checked", items_sent,
             segments_started, points_checked);
    $display("including idle requests, restarts, output hold-off and drain pause; %0d errors",
             error_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: line_point_generator_top.f
+incdir+src
src/lpg_pkg.sv
src/lpg_div.sv
src/line_point_generator_top.sv
src/lpg_checker.sv
sim/line_point_generator_top_tb.sv
